FILE: rtl/emss_pkg.sv
// shared types, register map and constants for the echo minimum seek head scanner
`default_nettype none

package emss_pkg;

  localparam int DIST_BITS_DEF = 16;
  localparam int ANGLE_LIMIT   = 90;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  // 0.1657 mm per us as an unsigned q0.16 factor
  localparam logic [13:0] MM_PER_US_Q16 = 14'd10859;

  localparam logic [15:0] NO_ECHO_RST      = 16'd10000;
  localparam logic [6:0]  SPAN_RST         = 7'd10;
  localparam logic [13:0] VARIATION_RST    = 14'd50;
  localparam logic [15:0] SACCADE_TICK_RST = 16'd200;
  localparam logic [15:0] MONITOR_TICK_RST = 16'd1000;

  typedef enum logic [2:0] {
    REG_NO_ECHO       = 3'd0,
    REG_SACCADE_SPAN  = 3'd1,
    REG_VARIATION     = 3'd2,
    REG_SACCADE_TICKS = 3'd3,
    REG_MONITOR_TICKS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] no_echo_mm;
    logic [6:0]  saccade_span;
    logic [13:0] monitor_variation;
    logic [15:0] saccade_ticks;
    logic [15:0] monitor_ticks;
  } cfg_t;

  typedef struct packed {
    logic [13:0] echo_width_us;
    logic        start_request;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] angle_out;
    logic              aligning;
    logic [15:0]       nearest_mm;
    logic              nearest_valid;
    logic [15:0]       latest_mm;
    logic              jump_seen;
    logic              sampled;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/emss_core.sv
// scan state and single-pass update for one tick transaction
`default_nettype none

module emss_core
  import emss_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_item_t  in_data,
  input  wire cfg_t      cfg,
  output out_item_t      res
);

  localparam int CW = (DIST_BITS > 15) ? DIST_BITS : 15;
  localparam logic signed [7:0] LIM     = 8'(ANGLE_LIMIT);
  localparam logic signed [7:0] NEG_LIM = 8'(-ANGLE_LIMIT);
  localparam logic signed [8:0] LIM9    = 9'(ANGLE_LIMIT);
  localparam logic signed [8:0] NEG_LIM9 = 9'(-ANGLE_LIMIT);
  localparam logic [DIST_BITS-1:0] NE_RST = DIST_BITS'(NO_ECHO_RST);

  logic [DIST_BITS-1:0] reading_now, reading_before, reading_oldest, nearest_latched;
  logic [DIST_BITS-1:0] now_next, before_next, oldest_next, nearest_next;
  logic signed [7:0]    head_pos, pos_next;
  logic [7:0]           head_step, step_next;
  logic [1:0]           scan_count, count_next;
  logic                 scan_active, active_next;
  logic                 jump_flag, jump_next;
  logic [15:0]          wait_left, wait_next;

  logic [DIST_BITS-1:0] ne;
  logic [27:0]          prod;
  logic [11:0]          mm_raw;
  logic [DIST_BITS-1:0] mm;
  logic [1:0]           count_inc;
  logic                 jump_hit, stray, going_down, at_hi, at_lo;
  logic [7:0]           span8;
  logic [7:0]           step_use;
  logic signed [8:0]    pos_sum;
  logic                 do_move, do_begin, do_finish, sampled;
  logic [DIST_BITS-1:0] found;

  function automatic logic beyond(input logic [DIST_BITS-1:0] a,
                                  input logic [DIST_BITS-1:0] b,
                                  input logic [14:0] lim);
    logic [DIST_BITS-1:0] d;
    d = (a > b) ? a - b : b - a;
    return CW'(d) > CW'(lim);
  endfunction

  assign ne     = DIST_BITS'(cfg.no_echo_mm);
  assign prod   = 28'(in_data.echo_width_us) * 28'(MM_PER_US_Q16);
  assign mm_raw = prod[27:16];
  assign mm     = (mm_raw == 12'd0) ? ne : DIST_BITS'(mm_raw);

  assign count_inc = (scan_count < 2'd2) ? scan_count + 2'd1 : scan_count;
  assign span8     = {1'b0, cfg.saccade_span};
  assign at_hi     = head_pos >= LIM;
  assign at_lo     = head_pos <= NEG_LIM;

  // comparisons below see the history as it stands after the shift
  assign jump_hit = beyond(mm, reading_now, {cfg.monitor_variation, 1'b0}) &&
                    beyond(mm, reading_before, {cfg.monitor_variation, 1'b0});
  assign stray    = beyond(mm, nearest_latched, {1'b0, cfg.monitor_variation}) &&
                    beyond(reading_now, nearest_latched, {1'b0, cfg.monitor_variation});
  assign going_down = (mm < reading_now) ||
                      (mm == ne && reading_now == ne && reading_before == ne);

  assign pos_sum = 9'(head_pos) + 9'(signed'(step_use));

  always_comb begin
    now_next     = reading_now;
    before_next  = reading_before;
    oldest_next  = reading_oldest;
    nearest_next = nearest_latched;
    pos_next     = head_pos;
    count_next   = scan_count;
    active_next  = scan_active;
    jump_next    = jump_flag;
    wait_next    = wait_left;
    step_use     = head_step;
    do_move      = 1'b0;
    do_begin     = 1'b0;
    do_finish    = 1'b0;
    sampled      = 1'b0;
    found        = mm;
    if (accept) begin
      if (in_data.start_request) begin
        do_begin = 1'b1;
      end else if (wait_left != 16'd0) begin
        wait_next = wait_left - 16'd1;
      end else begin
        sampled     = 1'b1;
        oldest_next = reading_before;
        before_next = reading_now;
        now_next    = mm;
        if (scan_active) begin
          count_next = count_inc;
          wait_next  = cfg.saccade_ticks;
          if (jump_hit) begin
            jump_next = 1'b1;
          end
          if (going_down) begin
            if (at_hi || at_lo) begin
              if (count_inc > 2'd1) begin
                do_finish = 1'b1;
                found     = mm;
              end else begin
                // bounce off the limit back toward the middle
                step_use = at_hi ? 8'd0 - span8 : span8;
                do_move  = 1'b1;
              end
            end else begin
              do_move = 1'b1;
            end
          end else begin
            // distance did not fall: turn around, previous reading may be the minimum
            step_use = 8'd0 - head_step;
            do_move  = 1'b1;
            if (reading_before >= reading_now && count_inc >= 2'd2 && reading_now < ne) begin
              do_finish = 1'b1;
              found     = reading_now;
            end
          end
        end else begin
          wait_next = cfg.monitor_ticks;
          if (stray) begin
            do_begin = 1'b1;
          end
        end
      end
    end
    step_next = step_use;
    if (do_move) begin
      if (pos_sum > LIM9) begin
        pos_next = LIM;
      end else if (pos_sum < NEG_LIM9) begin
        pos_next = NEG_LIM;
      end else begin
        pos_next = pos_sum[7:0];
      end
    end
    if (do_finish) begin
      nearest_next = found;
      active_next  = 1'b0;
      wait_next    = cfg.monitor_ticks;
    end
    if (do_begin) begin
      active_next = 1'b1;
      now_next    = ne;
      before_next = ne;
      step_next   = 8'd0 - head_step;
      count_next  = 2'd0;
      wait_next   = cfg.saccade_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_now     <= NE_RST;
      reading_before  <= NE_RST;
      reading_oldest  <= NE_RST;
      nearest_latched <= NE_RST;
      head_pos        <= 8'sd0;
      head_step       <= 8'(SPAN_RST);
      scan_count      <= 2'd0;
      scan_active     <= 1'b0;
      jump_flag       <= 1'b0;
      wait_left       <= 16'd0;
    end else if (accept) begin
      reading_now     <= now_next;
      reading_before  <= before_next;
      reading_oldest  <= oldest_next;
      nearest_latched <= nearest_next;
      head_pos        <= pos_next;
      head_step       <= step_next;
      scan_count      <= count_next;
      scan_active     <= active_next;
      jump_flag       <= jump_next;
      wait_left       <= wait_next;
    end
  end

  always_comb begin
    res.angle_out     = pos_next;
    res.aligning      = active_next;
    res.nearest_mm    = 16'(nearest_next);
    res.nearest_valid = nearest_next < ne;
    res.latest_mm     = 16'(now_next);
    res.jump_seen     = jump_next;
    res.sampled       = sampled;
  end

  a_jump_sticky: assert property (@(posedge clk) disable iff (rst)
    !rst && jump_flag |=> jump_flag)
    else $error("jump flag cleared outside reset");

  a_start_begins: assert property (@(posedge clk) disable iff (rst)
    !rst && accept && in_data.start_request |=>
      scan_active && scan_count == 2'd0 && wait_left == $past(cfg.saccade_ticks))
    else $error("start transaction did not begin a scan");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    !rst && accept && !in_data.start_request && wait_left != 16'd0 |=>
      wait_left == $past(wait_left) - 16'd1 && $stable(head_pos))
    else $error("countdown tick changed more than the counter");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !accept |=> $stable(head_pos) && $stable(wait_left) && $stable(reading_now))
    else $error("state moved without a transaction");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    !rst && accept && do_move |=> head_pos <= LIM && head_pos >= NEG_LIM)
    else $error("head angle beyond limit");

endmodule

`default_nettype wire

FILE: rtl/echo_min_seek_head_scanner_top.sv
// Echo minimum seek head scanner. Each input transaction is one millisecond tick
// with the latest echo width and a start request; each one yields exactly one
// result transaction carrying the head angle, scan status, latched nearest
// distance, latest reading, jump flag and whether a measurement was taken.
// A tick is processed in the cycle it is accepted and its result is registered
// into the output register or skid; a new tick is accepted every cycle while
// in_stall is low. Results sit in a two-entry output buffer (output register
// plus skid), so in_stall rises only when both entries hold results not yet
// taken. Registers are written through the APB-style port at byte addresses 4*i
// and read back the same way; write them only while no transaction is in flight.
`default_nettype none

module echo_min_seek_head_scanner_top
  import emss_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready
);

  cfg_t      cfg;
  reg_idx_t  reg_idx;
  logic      wr_en;
  logic      accept, pop;
  out_item_t res;
  out_item_t main_data, skid_data;
  logic      main_valid, skid_valid;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_echo_mm        <= NO_ECHO_RST;
      cfg.saccade_span      <= SPAN_RST;
      cfg.monitor_variation <= VARIATION_RST;
      cfg.saccade_ticks     <= SACCADE_TICK_RST;
      cfg.monitor_ticks     <= MONITOR_TICK_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NO_ECHO:       cfg.no_echo_mm        <= pwdata[15:0];
        REG_SACCADE_SPAN:  cfg.saccade_span      <= pwdata[6:0];
        REG_VARIATION:     cfg.monitor_variation <= pwdata[13:0];
        REG_SACCADE_TICKS: cfg.saccade_ticks     <= pwdata[15:0];
        REG_MONITOR_TICKS: cfg.monitor_ticks     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NO_ECHO:       prdata = DATA_BITS'(cfg.no_echo_mm);
      REG_SACCADE_SPAN:  prdata = DATA_BITS'(cfg.saccade_span);
      REG_VARIATION:     prdata = DATA_BITS'(cfg.monitor_variation);
      REG_SACCADE_TICKS: prdata = DATA_BITS'(cfg.saccade_ticks);
      REG_MONITOR_TICKS: prdata = DATA_BITS'(cfg.monitor_ticks);
      default:           prdata = '0;
    endcase
  end

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign pop       = main_valid && !out_stall;

  emss_core #(
    .DIST_BITS (DIST_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  // skid only fills when the output register is held by a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (accept) begin
      if (!main_valid || pop) begin
        main_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/echo_min_seek_head_scanner_top_tb.sv
// self-checking testbench for the echo minimum seek head scanner: predictor, driver and monitor
`timescale 1ns / 1ps

module echo_min_seek_head_scanner_top_tb;
  import emss_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  echo_min_seek_head_scanner_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted scanner state
  cfg_t        scan_cfg;
  logic [15:0] rd_now, rd_prev, rd_old, nearest;
  int          head_pos;
  logic [7:0]  head_step;
  logic [1:0]  scan_count;
  logic        scanning, jump_flag;
  logic [15:0] wait_left;

  in_item_t  tick_queue[$];
  out_item_t expected_results[$];
  int        ticks_queued = 0;
  int        ticks_taken = 0;
  int        errors = 0;
  logic      idle_en = 1'b0;
  logic      hold_off = 1'b0;
  int        in_burst = 0;
  int        out_burst = 0;

  int        n_results = 0;
  int        n_measured = 0;
  int        n_scans = 0;
  int        n_blocked = 0;
  logic      last_aligning = 1'b0;
  logic      jump_reported = 1'b0;

  function automatic int gap_mm(logic [15:0] a, logic [15:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic void turn_head();
    int p;
    p = head_pos + int'($signed(head_step));
    if (p > ANGLE_LIMIT) p = ANGLE_LIMIT;
    if (p < -ANGLE_LIMIT) p = -ANGLE_LIMIT;
    head_pos = p;
  endfunction

  function automatic void start_sweep();
    scanning   = 1'b1;
    rd_prev    = scan_cfg.no_echo_mm;
    rd_now     = scan_cfg.no_echo_mm;
    head_step  = 8'(8'd0 - head_step);
    scan_count = 2'd0;
    wait_left  = scan_cfg.saccade_ticks;
  endfunction

  function automatic void end_sweep(logic [15:0] found);
    nearest   = found;
    scanning  = 1'b0;
    wait_left = scan_cfg.monitor_ticks;
  endfunction

  function automatic void sweep_step();
    logic [15:0] ne;
    int          jump_lim;
    ne = scan_cfg.no_echo_mm;
    jump_lim = 2 * int'(scan_cfg.monitor_variation);
    if (scan_count < 2'd2) scan_count = scan_count + 2'd1;
    wait_left = scan_cfg.saccade_ticks;
    if (gap_mm(rd_now, rd_prev) > jump_lim && gap_mm(rd_now, rd_old) > jump_lim)
      jump_flag = 1'b1;
    if (rd_now < rd_prev || (rd_now == ne && rd_prev == ne && rd_old == ne)) begin
      if (head_pos <= -ANGLE_LIMIT || head_pos >= ANGLE_LIMIT) begin
        if (scan_count > 2'd1) begin
          end_sweep(rd_now);
        end else begin
          // bounce off the limit with a fresh step
          head_step = (head_pos >= ANGLE_LIMIT) ? 8'(8'd0 - {1'b0, scan_cfg.saccade_span})
                                                : {1'b0, scan_cfg.saccade_span};
          turn_head();
        end
      end else begin
        turn_head();
      end
    end else begin
      // distance did not fall: turn back, and stop if the previous reading was a minimum
      head_step = 8'(8'd0 - head_step);
      turn_head();
      if (rd_old >= rd_prev && scan_count >= 2'd2 && rd_prev < ne)
        end_sweep(rd_prev);
    end
  endfunction

  function automatic out_item_t advance_scanner(in_item_t t);
    out_item_t   r;
    logic [31:0] prod;
    logic [15:0] mm;
    logic        took;
    took = 1'b0;
    if (t.start_request) begin
      start_sweep();
    end else if (wait_left != 16'd0) begin
      wait_left = wait_left - 16'd1;
    end else begin
      prod = 32'(t.echo_width_us) * 32'(MM_PER_US_Q16);
      mm = prod[31:16];
      if (mm == 16'd0) mm = scan_cfg.no_echo_mm;
      took    = 1'b1;
      rd_old  = rd_prev;
      rd_prev = rd_now;
      rd_now  = mm;
      if (scanning) begin
        sweep_step();
      end else begin
        wait_left = scan_cfg.monitor_ticks;
        if (gap_mm(rd_now, nearest) > int'(scan_cfg.monitor_variation) &&
            gap_mm(rd_prev, nearest) > int'(scan_cfg.monitor_variation))
          start_sweep();
      end
    end
    r.angle_out     = 8'(head_pos);
    r.aligning      = scanning;
    r.nearest_mm    = nearest;
    r.nearest_valid = (nearest < scan_cfg.no_echo_mm);
    r.latest_mm     = rd_now;
    r.jump_seen     = jump_flag;
    r.sampled       = took;
    return r;
  endfunction

  task automatic reset_scanner();
    scan_cfg.no_echo_mm        = NO_ECHO_RST;
    scan_cfg.saccade_span      = SPAN_RST;
    scan_cfg.monitor_variation = VARIATION_RST;
    scan_cfg.saccade_ticks     = SACCADE_TICK_RST;
    scan_cfg.monitor_ticks     = MONITOR_TICK_RST;
    rd_now     = NO_ECHO_RST;
    rd_prev    = NO_ECHO_RST;
    rd_old     = NO_ECHO_RST;
    nearest    = NO_ECHO_RST;
    head_pos   = 0;
    head_step  = {1'b0, SPAN_RST};
    scan_count = 2'd0;
    scanning   = 1'b0;
    jump_flag  = 1'b0;
    wait_left  = 16'd0;
  endtask

  // driver: one tick transaction per accepted handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(advance_scanner(in_data));
        ticks_taken++;
      end
      if (in_valid && in_stall) begin
        n_blocked++;
      end else if (in_burst > 0) begin
        in_burst--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= tick_queue.pop_front();
        if (idle_en && $urandom_range(0, 7) == 0) in_burst = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int want, int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  out_item_t want;

  // monitor: compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("angle_out", int'($signed(want.angle_out)),
                      int'($signed(out_data.angle_out)));
          check_field("aligning", int'(want.aligning), int'(out_data.aligning));
          check_field("nearest_mm", int'(want.nearest_mm), int'(out_data.nearest_mm));
          check_field("nearest_valid", int'(want.nearest_valid), int'(out_data.nearest_valid));
          check_field("latest_mm", int'(want.latest_mm), int'(out_data.latest_mm));
          check_field("jump_seen", int'(want.jump_seen), int'(out_data.jump_seen));
          check_field("sampled", int'(want.sampled), int'(out_data.sampled));
        end
        n_results++;
        if (out_data.sampled) n_measured++;
        if (last_aligning && !out_data.aligning) n_scans++;
        last_aligning = out_data.aligning;
        if (out_data.jump_seen) jump_reported = 1'b1;
      end
      if (out_burst > 0) out_burst--;
      else if (idle_en && $urandom_range(0, 9) == 0) out_burst = $urandom_range(1, 19);
      out_stall <= hold_off || (out_burst > 0);
    end
  end

  task automatic program_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    // write lands here; turn straight into a read of the same register
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: readback of %s, expected %0d, got %0d", $time, idx.name(), value, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(cfg_t c);
    program_reg(REG_NO_ECHO, 32'(c.no_echo_mm));
    program_reg(REG_SACCADE_SPAN, 32'(c.saccade_span));
    program_reg(REG_VARIATION, 32'(c.monitor_variation));
    program_reg(REG_SACCADE_TICKS, 32'(c.saccade_ticks));
    program_reg(REG_MONITOR_TICKS, 32'(c.monitor_ticks));
    scan_cfg = c;
  endtask

  task automatic push_tick(int width, bit start);
    in_item_t t;
    t.echo_width_us = 14'(width);
    t.start_request = start;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // mostly distance valleys so scans find a minimum, mixed with noise and no-echo runs
  task automatic fill_random(int n);
    int made, kind, len, base, slope, ctr, w, d;
    made = 0;
    while (made < n) begin
      kind  = $urandom_range(0, 99);
      len   = $urandom_range(3, 14);
      base  = $urandom_range(60, 9000);
      slope = $urandom_range(20, 900);
      ctr   = $urandom_range(0, len - 1);
      if (kind < 8 && made < n) begin
        push_tick($urandom_range(0, 16383), 1'b1);
        made++;
      end
      for (int i = 0; i < len && made < n; i++) begin
        d = (i > ctr) ? i - ctr : ctr - i;
        if (kind < 60) w = base + slope * d + $urandom_range(0, 30);
        else if (kind < 75) w = $urandom_range(0, 16383);
        else if (kind < 88) w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        else w = base + $urandom_range(0, 40);
        if (w > 16383) w = 16383;
        push_tick(w, $urandom_range(0, 49) == 0);
        made++;
      end
    end
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(cfg_t c, int n, bit idle, bit squeeze);
    set_config(c);
    idle_en <= idle;
    push_tick($urandom_range(0, 16383), 1'b1);
    fill_random(n - 1);
    if (squeeze) begin
      // long receiver hold-off while ticks keep coming, to back up the input
      hold_off <= 1'b1;
      repeat (200) @(posedge clk);
      hold_off <= 1'b0;
    end
    drain();
  endtask

  function automatic cfg_t make_cfg(int ne, int span, int vary, int st, int mt);
    cfg_t c;
    c.no_echo_mm        = 16'(ne);
    c.saccade_span      = 7'(span);
    c.monitor_variation = 14'(vary);
    c.saccade_ticks     = 16'(st);
    c.monitor_ticks     = 16'(mt);
    return c;
  endfunction

  initial begin
    reset_scanner();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: no echo, max width, descent to the limit, realignment, jump, tiny widths
    set_config(make_cfg(10000, 45, 50, 0, 0));
    push_tick(0, 1'b0);
    push_tick(16383, 1'b1);
    push_tick(16383, 1'b0);
    push_tick(14000, 1'b0);
    push_tick(11000, 1'b0);
    push_tick(9000, 1'b0);
    push_tick(7000, 1'b0);
    push_tick(5000, 1'b0);
    push_tick(4000, 1'b0);
    push_tick(3000, 1'b0);
    push_tick(2000, 1'b0);
    push_tick(1500, 1'b0);
    push_tick(1400, 1'b0);
    push_tick(9000, 1'b0);
    push_tick(9000, 1'b0);
    push_tick(100, 1'b0);
    push_tick(9000, 1'b0);
    push_tick(100, 1'b0);
    push_tick(1, 1'b0);
    push_tick(6, 1'b0);
    push_tick(7, 1'b0);
    push_tick(8192, 1'b1);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    drain();

    run_phase(make_cfg(10000, 10, 50, 0, 1), 150, 1'b1, 1'b0);
    run_phase(make_cfg(65535, 90, 16383, 1, 0), 100, 1'b0, 1'b0);
    run_phase(make_cfg(0, 1, 0, 0, 0), 100, 1'b1, 1'b0);
    run_phase(make_cfg(3000, 0, 200, 2, 3), 80, 1'b1, 1'b0);
    run_phase(make_cfg(12345, 127, 100, 65535, 65535), 20, 1'b1, 1'b0);
    run_phase(make_cfg(5000, 30, 20, 0, 0), 150, 1'b0, 1'b1);
    run_phase(make_cfg(10000, 10, 50, 200, 1000), 30, 1'b1, 1'b0);
    run_phase(make_cfg(8000, 20, 40, 0, 0), 120, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    $display("run covered %0d ticks and %0d checked results, %0d of them measurements",
             ticks_taken, n_results, n_measured);
    $display("%0d scans completed, jump flag seen: %0d, input held off for %0d cycles",
             n_scans, jump_reported, n_blocked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout after %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/emss_pkg.sv
rtl/emss_core.sv
rtl/echo_min_seek_head_scanner_top.sv
tb/echo_min_seek_head_scanner_top_tb.sv
